### hw/rtl/msh_pkg.sv
// Shared package of the mesh/torus node addressing block.
// Holds the widths, register indexes and the structs passed between the
// cells and the output stage. No dependencies.
package msh_pkg;

  localparam int unsigned MaxAxes   = 4;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned IdBits    = 16;
  localparam int unsigned NumCells  = MaxAxes * CoordBits;
  localparam int unsigned CandBits  = 32;
  localparam int unsigned StrBits   = 33;

  localparam logic [2:0] REG_WRAP  = 3'd0;
  localparam logic [2:0] REG_AXES  = 3'd1;
  localparam logic [2:0] REG_SIZE0 = 3'd2;
  localparam logic [2:0] REG_SIZE1 = 3'd3;
  localparam logic [2:0] REG_SIZE2 = 3'd4;
  localparam logic [2:0] REG_SIZE3 = 3'd5;

  localparam logic ACT_NEIGHBOR = 1'b0;
  localparam logic ACT_DISTANCE = 1'b1;

  typedef struct packed {
    logic                    vld;
    logic                    action;
    logic [IdBits-1:0]       node_a;
    logic [1:0]              axis;
    logic                    toward_up;
    logic [5:0]              port_index;
    logic                    inv;
    logic [IdBits-1:0]       rem_a;
    logic [IdBits-1:0]       rem_b;
    logic [NumCells-1:0]     ca;
    logic [NumCells-1:0]     cb;
  } item_t;

  typedef struct packed {
    logic                           wrap;
    logic [2:0]                     axes;
    logic [MaxAxes-1:0][8:0]        es;
    logic [MaxAxes:0][StrBits-1:0]  stride;
  } cfg_t;

endpackage

### hw/rtl/msh_cfg.sv
// Configuration registers and the derived axis strides and node count.
// Depends on msh_pkg.
module msh_cfg import msh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  output cfg_t       cfg,
  output logic       busy
);

  logic                     wrap_r;
  logic [2:0]               axes_r;
  logic [MaxAxes-1:0][8:0]  size_r;
  logic [2:0]               n_r, n_nxt;
  logic [MaxAxes-1:0][8:0]  es_r, es_nxt;
  logic [16:0]              str2_r;
  logic [24:0]              str3_r;
  logic [StrBits-1:0]       cnt_r;
  logic [2:0]               busy_r;

  always_comb begin
    n_nxt = axes_r;
    if (axes_r == 3'd0) n_nxt = 3'd1;
    else if (axes_r > 3'(MaxAxes)) n_nxt = 3'(MaxAxes);
    for (int i = 0; i < MaxAxes; i++) begin
      es_nxt[i] = size_r[i];
      if (size_r[i] == 9'd0) es_nxt[i] = 9'd1;
      else if (size_r[i] > 9'd256) es_nxt[i] = 9'd256;
      if (3'(i) >= n_nxt) es_nxt[i] = 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b0;
      axes_r <= 3'd2;
      size_r <= {9'd1, 9'd1, 9'd4, 9'd4};
      busy_r <= 3'd5;
    end else begin
      if (cfg_wr_en) begin
        busy_r <= 3'd5;
        unique case (cfg_index)
          REG_WRAP:  wrap_r    <= cfg_wdata[0];
          REG_AXES:  axes_r    <= cfg_wdata[2:0];
          REG_SIZE0: size_r[0] <= cfg_wdata;
          REG_SIZE1: size_r[1] <= cfg_wdata;
          REG_SIZE2: size_r[2] <= cfg_wdata;
          REG_SIZE3: size_r[3] <= cfg_wdata;
          default: ;
        endcase
      end else if (busy_r != 3'd0) begin
        busy_r <= busy_r - 3'd1;
      end
    end
    n_r    <= n_nxt;
    es_r   <= es_nxt;
    str2_r <= 17'(es_r[0] * es_r[1]);
    str3_r <= 25'(str2_r * es_r[2]);
    cnt_r  <= StrBits'(str3_r * es_r[3]);
  end

  assign busy           = (busy_r != 3'd0);
  assign cfg.wrap       = wrap_r;
  assign cfg.axes       = n_r;
  assign cfg.es         = es_r;
  assign cfg.stride[0]  = StrBits'(1);
  assign cfg.stride[1]  = StrBits'(es_r[0]);
  assign cfg.stride[2]  = StrBits'(str2_r);
  assign cfg.stride[3]  = StrBits'(str3_r);
  assign cfg.stride[4]  = cnt_r;

endmodule

### hw/rtl/msh_cell.sv
// One cell of the coordinate chain: resolves one coordinate bit of both
// node ids by a compare and subtract against a shifted stride. Depends on msh_pkg.
module msh_cell import msh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [4:0]          bit_sel,
  input  logic [CandBits-1:0] cand,
  input  item_t               d,
  output item_t               q
);

  item_t q_r, q_nxt;
  logic  ge_a, ge_b;

  always_comb begin
    ge_a  = CandBits'(d.rem_a) >= cand;
    ge_b  = CandBits'(d.rem_b) >= cand;
    q_nxt = d;
    if (ge_a) q_nxt.rem_a = d.rem_a - cand[IdBits-1:0];
    if (ge_b) q_nxt.rem_b = d.rem_b - cand[IdBits-1:0];
    q_nxt.ca[bit_sel] = ge_a;
    q_nxt.cb[bit_sel] = ge_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

### hw/rtl/msh_out.sv
// Output stage: forms the neighbor id, port, direction and distance from
// the resolved coordinates and holds the result register. Depends on msh_pkg.
module msh_out import msh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  cfg_t        cfg,
  input  item_t       d,
  output logic        out_tvalid,
  output logic [39:0] out_tdata
);

  logic                 out_tvalid_r;
  logic [IdBits-1:0]    node_r, node_nxt;
  logic [6:0]           port_r, port_nxt;
  logic                 has_r, has_nxt;
  logic [2:0]           dir_r, dir_nxt;
  logic [9:0]           dist_r, dist_nxt;
  logic                 inv_r;
  logic [CoordBits-1:0] c;
  logic [8:0]           sz;
  logic [StrBits-1:0]   st, sn, span;
  logic                 at_edge;
  logic [7:0]           da, db;

  always_comb begin
    c       = d.ca[{d.axis, 3'b000} +: CoordBits];
    sz      = cfg.es[d.axis];
    st      = cfg.stride[d.axis];
    sn      = cfg.stride[3'({1'b0, d.axis}) + 3'd1];
    span    = sn - st;
    at_edge = d.toward_up ? ({1'b0, c} >= sz - 9'd1) : (c == 8'd0);
    dir_nxt = {d.axis, ~d.toward_up};
    node_nxt = '0;
    port_nxt = '0;
    has_nxt  = 1'b0;
    dist_nxt = '0;
    da       = '0;
    db       = '0;
    if (d.action == ACT_NEIGHBOR) begin
      if (!d.inv && (3'({1'b0, d.axis}) < cfg.axes) &&
          !(d.toward_up && d.port_index == 6'd0) && !(at_edge && !cfg.wrap)) begin
        has_nxt = 1'b1;
        if (d.toward_up) begin
          port_nxt = 7'(d.port_index) - 7'd1;
          node_nxt = at_edge ? d.node_a - span[IdBits-1:0] : d.node_a + st[IdBits-1:0];
        end else begin
          port_nxt = 7'(d.port_index) + 7'd1;
          node_nxt = at_edge ? d.node_a + span[IdBits-1:0] : d.node_a - st[IdBits-1:0];
        end
      end
    end else begin
      dir_nxt = 3'd0;
      if (!d.inv) begin
        for (int i = 0; i < MaxAxes; i++) begin
          da = d.ca[i*CoordBits +: CoordBits];
          db = d.cb[i*CoordBits +: CoordBits];
          dist_nxt = dist_nxt + 10'((da >= db) ? da - db : db - da);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= d.vld;
      node_r <= node_nxt;
      port_r <= port_nxt;
      has_r  <= has_nxt;
      dir_r  <= dir_nxt;
      dist_r <= dist_nxt;
      inv_r  <= d.inv;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, inv_r, dist_r, dir_r, has_r, port_r, node_r};

  property p_no_link_when_invalid;
    @(posedge clk) disable iff (!rst_n) out_tvalid_r |-> !(has_r && inv_r);
  endproperty
  a_no_link_when_invalid: assert property (p_no_link_when_invalid)
    else $error("neighbor reported for invalid node");

endmodule

### hw/rtl/mesh_torus_neighbor_and_distance.sv
// Top level of the mesh/torus node addressing block: config registers,
// a 32-cell coordinate chain and the output stage. Depends on msh_pkg.
//
//  port group | dir | contents
//  in_*       | in  | query transfer: tuser action, tdata node ids/axis/port
//  out_*      | out | result transfer: neighbor, port, direction, distance
//  cfg_*      | in  | register writes, one per cycle
//
// One query is taken per cycle unless the chain stalls or the input is held
// off; a result passes through the 32 cells (one coordinate bit each) and
// then the output register, the first cell loading at the transfer edge itself.
// The whole chain holds while a result waits on out_tready.
// After reset or a register write the input is held off while the strides
// and the node count settle.
module mesh_torus_neighbor_and_distance import msh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // action
  input  logic [47:0] in_tdata,   // node_a, node_b, axis, toward_up, port_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // neighbor_node, neighbor_port, has_neighbor,
                                  // link_direction, distance, node_invalid
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  cfg_t  cfg;
  logic  busy;
  logic  adv;
  item_t head;
  item_t chain [NumCells+1];

  msh_cfg u_cfg (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata, .cfg(cfg), .busy(busy)
  );

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && !busy;

  always_comb begin
    head            = '0;
    head.vld        = in_tvalid && !busy;
    head.action     = in_tuser;
    head.node_a     = in_tdata[15:0];
    head.axis       = in_tdata[33:32];
    head.toward_up  = in_tdata[34];
    head.port_index = in_tdata[40:35];
    head.rem_a      = in_tdata[15:0];
    head.rem_b      = in_tdata[31:16];
    head.inv        = (StrBits'(in_tdata[15:0]) >= cfg.stride[MaxAxes]) ||
                      ((in_tuser == ACT_DISTANCE) &&
                       (StrBits'(in_tdata[31:16]) >= cfg.stride[MaxAxes]));
  end

  assign chain[0] = head;

  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    localparam int unsigned Ax = MaxAxes - 1 - j / CoordBits;
    localparam int unsigned Sh = CoordBits - 1 - j % CoordBits;
    logic [CandBits-1:0] cand;
    assign cand = CandBits'(cfg.stride[Ax]) << Sh;
    msh_cell u_cell (
      .clk, .rst_n, .en(adv), .bit_sel(5'(NumCells - 1 - j)), .cand(cand),
      .d(chain[j]), .q(chain[j+1])
    );
  end

  msh_out u_out (
    .clk, .rst_n, .en(adv), .cfg(cfg), .d(chain[NumCells]),
    .out_tvalid(out_tvalid), .out_tdata(out_tdata)
  );

  property p_cfg_blocks;
    @(posedge clk) disable iff (!rst_n) cfg_wr_en |=> !in_tready;
  endproperty
  a_cfg_blocks: assert property (p_cfg_blocks) else $error("input open after config write");

  property p_stall_holds;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> $stable(out_tdata) && !$past(in_tready);
  endproperty
  a_stall_holds: assert property (p_stall_holds) else $error("chain moved during stall");

  property p_neighbor_no_dist;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && out_tdata[23]) |-> (out_tdata[36:27] == 10'd0);
  endproperty
  a_neighbor_no_dist: assert property (p_neighbor_no_dist)
    else $error("distance set on neighbor result");

endmodule

### tb/mesh_torus_neighbor_and_distance_tb.sv
// Testbench of the mesh/torus node addressing block: neighbor and distance
// queries under several network settings, checked against a built-in predictor.
// Depends on msh_pkg and the mesh_torus_neighbor_and_distance RTL.
`timescale 1ns / 100ps

class query_scoreboard;
  typedef struct packed {
    logic [15:0] nnode;
    logic [6:0]  nport;
    logic        has;
    logic [2:0]  dir;
    logic [9:0]  hops;
    logic        inv;
  } answer_t;

  bit         wrap;
  logic [2:0] axes;
  logic [8:0] sizes [4];
  answer_t    pending [$];
  int         mismatches;

  function void reset_regs();
    wrap = 0;
    axes = 2;
    sizes[0] = 4;
    sizes[1] = 4;
    sizes[2] = 1;
    sizes[3] = 1;
  endfunction

  function void write_reg(logic [2:0] idx, logic [8:0] val);
    case (idx)
      msh_pkg::REG_WRAP:  wrap = val[0];
      msh_pkg::REG_AXES:  axes = val[2:0];
      msh_pkg::REG_SIZE0: sizes[0] = val;
      msh_pkg::REG_SIZE1: sizes[1] = val;
      msh_pkg::REG_SIZE2: sizes[2] = val;
      msh_pkg::REG_SIZE3: sizes[3] = val;
      default: ;
    endcase
  endfunction

  function int unsigned axis_len(int i);
    int unsigned s;
    s = sizes[i];
    if (s == 0) s = 1;
    if (s > 256) s = 256;
    return s;
  endfunction

  function int unsigned axes_used();
    int unsigned n;
    n = axes;
    if (n == 0) n = 1;
    if (n > 4) n = 4;
    return n;
  endfunction

  function void note_query(logic action, logic [47:0] d);
    answer_t r;
    longint unsigned cnt, na, nb, id;
    longint unsigned ca [4], cb [4];
    int unsigned n, ax, s;
    logic up;
    logic [5:0] port;
    bit ok;
    r = '0;
    na = d[15:0];
    nb = d[31:16];
    ax = d[33:32];
    up = d[34];
    port = d[40:35];
    n = axes_used();
    cnt = 1;
    for (int i = 0; i < n; i++) cnt *= axis_len(i);
    for (int i = 0; i < 4; i++) begin
      ca[i] = 0;
      cb[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      ca[i] = na % axis_len(i);
      na = na / axis_len(i);
      cb[i] = nb % axis_len(i);
      nb = nb / axis_len(i);
    end
    if (action == msh_pkg::ACT_NEIGHBOR) begin
      r.dir = 3'(ax * 2 + (up ? 0 : 1));
      if (d[15:0] >= cnt) begin
        r.inv = 1;
      end else if (ax < n && !(up && port == 0)) begin
        s = axis_len(ax);
        ok = 1;
        if (up) begin
          if (ca[ax] >= s - 1) begin
            if (wrap) ca[ax] = 0; else ok = 0;
          end else ca[ax]++;
        end else begin
          if (ca[ax] == 0) begin
            if (wrap) ca[ax] = s - 1; else ok = 0;
          end else ca[ax]--;
        end
        if (ok) begin
          id = 0;
          for (int i = n - 1; i >= 0; i--) id = id * axis_len(i) + ca[i];
          r.nnode = id[15:0];
          r.nport = up ? {1'b0, port} - 7'd1 : {1'b0, port} + 7'd1;
          r.has = 1;
        end
      end
    end else begin
      if (d[15:0] >= cnt || d[31:16] >= cnt) begin
        r.inv = 1;
      end else begin
        id = 0;
        for (int i = 0; i < n; i++) id += (ca[i] >= cb[i]) ? ca[i] - cb[i] : cb[i] - ca[i];
        r.hops = id[9:0];
      end
    end
    pending = {pending, r};
  endfunction

  function void check_result(logic [39:0] t);
    answer_t got, exp_r;
    got = {t[0+:16], t[16+:7], t[23], t[24+:3], t[27+:10], t[37]};
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result %h", t);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: node %0d/%0d port %0d/%0d has %0d/%0d dir %0d/%0d ",
                  "dist %0d/%0d inv %0d/%0d (exp/got)"},
          exp_r.nnode, got.nnode, exp_r.nport, got.nport, exp_r.has, got.has,
          exp_r.dir, got.dir, exp_r.hops, got.hops, exp_r.inv, got.inv);
    end
  endfunction
endclass

module mesh_torus_neighbor_and_distance_tb;
  import msh_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_wdata;

  query_scoreboard board;
  bit driving_done;
  int unsigned out_hold;

  mesh_torus_neighbor_and_distance dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic set_network(bit w, logic [2:0] n, logic [8:0] s0, logic [8:0] s1,
                             logic [8:0] s2, logic [8:0] s3);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_WRAP, 9'(w));
    write_reg(REG_AXES, 9'(n));
    write_reg(REG_SIZE0, s0);
    write_reg(REG_SIZE1, s1);
    write_reg(REG_SIZE2, s2);
    write_reg(REG_SIZE3, s3);
    cfg_wr_en <= 0;
  endtask

  task automatic send_query(logic act, logic [15:0] a, logic [15:0] b, logic [1:0] ax,
                            logic up, logic [5:0] port, bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {7'd0, port, up, ax, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_query(act, {7'd0, port, up, ax, b, a});
  endtask

  task automatic random_queries(int count, int unsigned span);
    logic [15:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      b = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
      send_query($urandom_range(0, 1), a, b, $urandom_range(0, 3), $urandom_range(0, 1),
                 ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom), i % 200 >= 40);
    end
    in_tvalid <= 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (!rst_n || driving_done) begin
      out_hold = 0;
      out_tready <= 1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 0;
    end else begin
      out_hold = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    int unsigned waited;
    board = new();
    board.reset_regs();
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    cfg_wr_en = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    driving_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed queries on the reset 4x4 mesh.
    send_query(ACT_NEIGHBOR, 0, 0, 0, 1, 5, 0);
    send_query(ACT_NEIGHBOR, 0, 0, 0, 0, 5, 0);
    send_query(ACT_NEIGHBOR, 3, 0, 0, 1, 63, 0);
    send_query(ACT_NEIGHBOR, 15, 0, 1, 1, 1, 0);
    send_query(ACT_NEIGHBOR, 5, 0, 1, 0, 63, 0);
    send_query(ACT_NEIGHBOR, 5, 0, 0, 1, 0, 0);
    send_query(ACT_NEIGHBOR, 5, 0, 2, 1, 3, 0);
    send_query(ACT_NEIGHBOR, 5, 0, 3, 0, 3, 0);
    send_query(ACT_NEIGHBOR, 16, 0, 0, 1, 3, 0);
    send_query(ACT_NEIGHBOR, 16'hFFFF, 0, 1, 0, 3, 0);
    send_query(ACT_DISTANCE, 0, 15, 0, 0, 0, 0);
    send_query(ACT_DISTANCE, 15, 0, 3, 1, 63, 0);
    send_query(ACT_DISTANCE, 6, 6, 0, 0, 0, 0);
    send_query(ACT_DISTANCE, 0, 16, 0, 0, 0, 0);
    send_query(ACT_DISTANCE, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    in_tvalid <= 0;

    set_network(1, 2, 4, 4, 1, 1);
    send_query(ACT_NEIGHBOR, 3, 0, 0, 1, 9, 0);
    send_query(ACT_NEIGHBOR, 0, 0, 0, 0, 63, 0);
    send_query(ACT_NEIGHBOR, 12, 0, 1, 1, 9, 0);
    send_query(ACT_NEIGHBOR, 2, 0, 1, 0, 9, 0);
    random_queries(150, 20);

    set_network(0, 4, 256, 256, 1, 1);
    random_queries(150, 16'hFFFF);
    set_network(1, 4, 256, 256, 1, 1);
    random_queries(150, 16'hFFFF);
    set_network(1, 0, 0, 300, 511, 0);
    random_queries(120, 300);
    set_network(0, 7, 5, 3, 7, 2);
    random_queries(150, 220);
    set_network(1, 4, 3, 5, 2, 6);
    random_queries(150, 200);
    set_network(1, 1, 256, 9, 9, 9);
    random_queries(120, 300);
    set_network(0, 3, 1, 16, 2, 1);
    random_queries(120, 40);
    set_network(1, 3, 2, 1, 255, 1);
    random_queries(150, 520);

    driving_done = 1;
    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
